// ===== hw/rtl/modexp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared types and constants for the modular exponentiation unit.
// ----------------------------------------------------------------------------
package modexp_pkg;

   localparam int unsigned FIELD_W = 32;
   localparam logic [FIELD_W-1:0] MODULUS_RESET = 32'd3233;

   typedef enum logic [1:0] {
      OP_REDUCE,
      OP_MULT,
      OP_SQUARE
   } op_type;

   typedef struct packed {
      logic   load;
      logic   mul_load;
      op_type op;
      logic   mul_step;
      logic   wb_base;
      logic   wb_res;
      logic   exp_shift;
   } cmd_type;

   typedef struct packed {
      logic exp_zero;
      logic exp_lsb;
      logic mod_zero;
      logic my_zero;
   } status_type;

endpackage

// ===== hw/rtl/modexp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_datapath
// Operand registers, modulus register and a bit-serial add-and-double
// modular multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module modexp_datapath #(
   parameter int unsigned WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  modexp_pkg::cmd_type              cmd,
   output modexp_pkg::status_type           status,
   input  logic [modexp_pkg::FIELD_W-1:0]   req_base,
   input  logic [modexp_pkg::FIELD_W-1:0]   req_exponent,
   input  logic                             csr_write,
   input  logic [modexp_pkg::FIELD_W-1:0]   csr_modulus,
   output logic [modexp_pkg::FIELD_W-1:0]   rsp_power
);

   logic [WIDTH-1:0] mod_ff;
   logic [WIDTH-1:0] base_ff, base_in;
   logic [WIDTH-1:0] exp_ff, exp_in;
   logic [WIDTH-1:0] res_ff, res_in;
   logic [WIDTH-1:0] mx_ff, mx_in;
   logic [WIDTH-1:0] my_ff, my_in;
   logic [WIDTH-1:0] mp_ff, mp_in;
   logic [WIDTH-1:0] one_mod;
   logic [WIDTH-1:0] load_base;
   logic [WIDTH-1:0] load_exp;

   // (x + y) mod m, x and y below m
   function automatic logic [WIDTH-1:0] add_mod(
      input logic [WIDTH-1:0] x,
      input logic [WIDTH-1:0] y,
      input logic [WIDTH-1:0] m
   );
      logic [WIDTH-1:0] gap;
      gap = m - y;
      if (x >= gap) begin
         return x - gap;
      end
      return x + y;
   endfunction

   assign one_mod   = (mod_ff > WIDTH'(1)) ? WIDTH'(1) : '0;
   assign load_base = WIDTH'(req_base);
   assign load_exp  = WIDTH'(req_exponent);

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= WIDTH'(modexp_pkg::MODULUS_RESET);
      end else if (csr_write) begin
         mod_ff <= WIDTH'(csr_modulus);
      end
   end

   always_comb begin
      base_in = base_ff;
      exp_in  = exp_ff;
      res_in  = res_ff;
      mx_in   = mx_ff;
      my_in   = my_ff;
      mp_in   = mp_ff;
      if (cmd.load) begin
         base_in = load_base;
         exp_in  = load_exp;
         res_in  = (load_exp == '0) ? WIDTH'(1) : one_mod;
      end
      if (cmd.wb_base) begin
         base_in = mp_ff;
      end
      if (cmd.wb_res) begin
         res_in = mp_ff;
      end
      if (cmd.exp_shift) begin
         exp_in = exp_ff >> 1;
      end
      if (cmd.mul_load) begin
         mp_in = '0;
         my_in = base_ff;
         unique case (cmd.op)
            modexp_pkg::OP_REDUCE: mx_in = one_mod;
            modexp_pkg::OP_MULT:   mx_in = res_ff;
            modexp_pkg::OP_SQUARE: mx_in = base_ff;
            default:               mx_in = base_ff;
         endcase
      end else if (cmd.mul_step) begin
         mp_in = my_ff[0] ? add_mod(mp_ff, mx_ff, mod_ff) : mp_ff;
         mx_in = add_mod(mx_ff, mx_ff, mod_ff);
         my_in = my_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      exp_ff  <= exp_in;
      res_ff  <= res_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      mp_ff   <= mp_in;
   end

   assign status.exp_zero = (exp_ff == '0);
   assign status.exp_lsb  = exp_ff[0];
   assign status.mod_zero = (mod_ff == '0);
   assign status.my_zero  = (my_ff == '0);

   assign rsp_power = modexp_pkg::FIELD_W'(res_ff);

   // operands of the multiplier stay reduced while it runs
   a_operands_reduced: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_step |-> (mp_ff < mod_ff) && (mx_ff < mod_ff))
      else $error("multiplier operand not reduced");

endmodule

// ===== hw/rtl/modexp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_ctrl
// Sequencer: unless the exponent or modulus is zero, base reduction, then per
// exponent bit an optional multiply and a square, each run bit-serially on the datapath multiplier.
// ----------------------------------------------------------------------------
module modexp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output logic                    rsp_valid,
   input  modexp_pkg::status_type  status,
   output modexp_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_RED,
      S_RED_RUN,
      S_BIT,
      S_MUL_RUN,
      S_SQR_RUN
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;
   logic      valid_ff, valid_in;
   logic      accept;

   assign accept = start && !busy_ff;

   always_comb begin
      state_in = state_ff;
      busy_in  = busy_ff;
      valid_in = 1'b0;
      cmd      = '0;
      cmd.op   = modexp_pkg::OP_REDUCE;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               busy_in  = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.exp_zero || status.mod_zero) begin
               valid_in = 1'b1;
               busy_in  = 1'b0;
               state_in = S_IDLE;
            end else begin
               state_in = S_RED;
            end
         end
         S_RED: begin
            cmd.mul_load = 1'b1;
            cmd.op       = modexp_pkg::OP_REDUCE;
            state_in     = S_RED_RUN;
         end
         S_RED_RUN: begin
            if (status.my_zero) begin
               cmd.wb_base = 1'b1;
               state_in    = S_BIT;
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         S_BIT: begin
            if (status.exp_zero) begin
               valid_in = 1'b1;
               busy_in  = 1'b0;
               state_in = S_IDLE;
            end else if (status.exp_lsb) begin
               cmd.mul_load = 1'b1;
               cmd.op       = modexp_pkg::OP_MULT;
               state_in     = S_MUL_RUN;
            end else begin
               cmd.mul_load = 1'b1;
               cmd.op       = modexp_pkg::OP_SQUARE;
               state_in     = S_SQR_RUN;
            end
         end
         S_MUL_RUN: begin
            if (status.my_zero) begin
               cmd.wb_res   = 1'b1;
               cmd.mul_load = 1'b1;
               cmd.op       = modexp_pkg::OP_SQUARE;
               state_in     = S_SQR_RUN;
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         S_SQR_RUN: begin
            if (status.my_zero) begin
               cmd.wb_base   = 1'b1;
               cmd.exp_shift = 1'b1;
               state_in      = S_BIT;
            end else begin
               cmd.mul_step = 1'b1;
            end
         end
         default: begin
            busy_in  = 1'b0;
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("busy not raised after accepted item");

   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> !busy_ff && (state_ff == S_IDLE))
      else $error("result strobe while busy");

   a_busy_state: assert property (@(posedge clock) disable iff (reset)
      busy_ff == (state_ff != S_IDLE))
      else $error("busy flag disagrees with state");

endmodule

// ===== hw/rtl/modular_exponentiation_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_unit
// Computes base^exponent mod modulus by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// Usage:
//  - csr_valid/csr_ready write csr_modulus (reset value 3233); csr_ready is
//    high while the unit is idle and start is low, so a write never meets
//    an item at the same edge.
//  - An item (req_base, req_exponent) is taken when start is high and busy
//    is low. busy stays high until the result is presented.
//  - rsp_power is valid for exactly one cycle while rsp_valid is high; the
//    receiver cannot stall and must take it in that cycle.
//  - Sequence from the accepting edge to the edge that takes the result:
//    a zero exponent or zero modulus ends in the check state. Otherwise the
//    base reduction, then per exponent bit up to the top set bit a multiply
//    on set bits and a square. Each modular multiply runs on one shared
//    bit-serial add-and-double unit, one multiplier bit per cycle. One item
//    at a time; busy falls as the strobe rises, so the next item may be
//    taken in the strobe cycle.
//  - Synchronous reset returns to idle and restores the modulus.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit #(
   parameter int unsigned WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [modexp_pkg::FIELD_W-1:0]  req_base,
   input  logic [modexp_pkg::FIELD_W-1:0]  req_exponent,
   output logic                            rsp_valid,
   output logic [modexp_pkg::FIELD_W-1:0]  rsp_power,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [modexp_pkg::FIELD_W-1:0]  csr_modulus
);

   modexp_pkg::cmd_type    cmd;
   modexp_pkg::status_type status;
   logic                   csr_write;

   assign csr_ready = !busy && !start;
   assign csr_write = csr_valid && csr_ready;

   modexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   modexp_datapath #(
      .WIDTH (WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_base     (req_base),
      .req_exponent (req_exponent),
      .csr_write    (csr_write),
      .csr_modulus  (csr_modulus),
      .rsp_power    (rsp_power)
   );

endmodule

// ===== tb/sv/tb_modular_exponentiation_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_exponentiation_unit
// Self-checking bench for the modular exponentiation unit. A queue of items
// and modulus writes feeds a clocked driver; every accepted item is predicted
// with double-width modular arithmetic and the monitor compares each result
// in order. Covers reset modulus, unit and zero modulus, full-width and
// power-of-two moduli, edge-case bases and exponents, with random idling.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation_unit;

   typedef struct {
      bit                             is_write;
      logic [modexp_pkg::FIELD_W-1:0] modulus;
      logic [modexp_pkg::FIELD_W-1:0] base;
      logic [modexp_pkg::FIELD_W-1:0] exponent;
      int unsigned                    gap;
   } modexp_job_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic [modexp_pkg::FIELD_W-1:0] req_base = '0;
   logic [modexp_pkg::FIELD_W-1:0] req_exponent = '0;
   logic                           rsp_valid;
   logic [modexp_pkg::FIELD_W-1:0] rsp_power;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [modexp_pkg::FIELD_W-1:0] csr_modulus = '0;

   modexp_job_type                 job_queue[$];
   logic [modexp_pkg::FIELD_W-1:0] expected_powers[$];
   logic [modexp_pkg::FIELD_W-1:0] model_modulus = modexp_pkg::MODULUS_RESET;
   int unsigned                    hold_off = 0;
   bit                             gap_taken = 0;
   bit                             stim_done = 0;
   bit                             no_idle = 0;
   int unsigned                    items_sent = 0;
   int unsigned                    writes_done = 0;
   int unsigned                    powers_checked = 0;
   int unsigned                    mismatches = 0;

   modular_exponentiation_unit u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_base     (req_base),
      .req_exponent (req_exponent),
      .rsp_valid    (rsp_valid),
      .rsp_power    (rsp_power),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_modulus  (csr_modulus)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // right-to-left square-and-multiply, products kept at double width
   function automatic logic [modexp_pkg::FIELD_W-1:0] predict_power(
      logic [modexp_pkg::FIELD_W-1:0] b,
      logic [modexp_pkg::FIELD_W-1:0] e,
      logic [modexp_pkg::FIELD_W-1:0] n
   );
      logic [2*modexp_pkg::FIELD_W-1:0] acc;
      logic [2*modexp_pkg::FIELD_W-1:0] sq;
      logic [2*modexp_pkg::FIELD_W-1:0] n_wide;
      logic [2*modexp_pkg::FIELD_W-1:0] b_wide;
      logic [modexp_pkg::FIELD_W-1:0]   bits;
      if (e == '0) return modexp_pkg::FIELD_W'(1);
      if (n == '0) return '0;
      n_wide = {{modexp_pkg::FIELD_W{1'b0}}, n};
      b_wide = {{modexp_pkg::FIELD_W{1'b0}}, b};
      acc = (2*modexp_pkg::FIELD_W)'(1);
      sq = b_wide % n_wide;
      bits = e;
      while (bits != '0) begin
         if (bits[0]) acc = (acc * sq) % n_wide;
         sq = (sq * sq) % n_wide;
         bits = bits >> 1;
      end
      acc = acc % n_wide;
      return acc[modexp_pkg::FIELD_W-1:0];
   endfunction

   function automatic int unsigned draw_gap();
      if (no_idle) return 0;
      return $urandom_range(0, 18);
   endfunction

   task automatic queue_item(logic [modexp_pkg::FIELD_W-1:0] b,
                             logic [modexp_pkg::FIELD_W-1:0] e);
      modexp_job_type job;
      job.is_write = 1'b0;
      job.modulus  = '0;
      job.base     = b;
      job.exponent = e;
      job.gap      = draw_gap();
      job_queue.push_back(job);
   endtask

   task automatic queue_modulus(logic [modexp_pkg::FIELD_W-1:0] n);
      modexp_job_type job;
      job.is_write = 1'b1;
      job.modulus  = n;
      job.base     = '0;
      job.exponent = '0;
      job.gap      = draw_gap();
      job_queue.push_back(job);
   endtask

   function automatic logic [modexp_pkg::FIELD_W-1:0] pick_base(
      logic [modexp_pkg::FIELD_W-1:0] n
   );
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 1;
         2:       return n - 1;
         3:       return n;
         4:       return n + 1;
         5:       return '1;
         6:       return $urandom_range(2, 1000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [modexp_pkg::FIELD_W-1:0] pick_exponent();
      logic [modexp_pkg::FIELD_W-1:0] one_bit;
      one_bit = 1;
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return '1;
         2:       return one_bit << $urandom_range(0, modexp_pkg::FIELD_W - 1);
         3, 4, 5: return $urandom_range(1, 300);
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_random_phase(logic [modexp_pkg::FIELD_W-1:0] n,
                                     int unsigned count);
      no_idle = ($urandom_range(0, 3) == 0);
      queue_modulus(n);
      repeat (count) queue_item(pick_base(n), pick_exponent());
   endtask

   // driver: one nonblocking update per output per edge
   always @(posedge clock) begin
      logic           next_start;
      logic           next_valid;
      modexp_job_type head;
      if (reset) begin
         start     <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         next_start = start;
         next_valid = csr_valid;
         if (start && !busy) begin
            expected_powers.push_back(predict_power(req_base, req_exponent, model_modulus));
            items_sent++;
            next_start = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            model_modulus = csr_modulus;
            writes_done++;
            next_valid = 1'b0;
         end
         if (!next_start && !next_valid) begin
            if (hold_off != 0) begin
               if (!busy) hold_off--;
            end else if (job_queue.size() == 0) begin
               stim_done <= 1;
            end else begin
               head = job_queue[0];
               if (!gap_taken) begin
                  hold_off = head.gap;
                  gap_taken = 1;
               end
               if (hold_off == 0) begin
                  if (!head.is_write) begin
                     next_start = 1'b1;
                     req_base <= head.base;
                     req_exponent <= head.exponent;
                     void'(job_queue.pop_front());
                     gap_taken = 0;
                  end else if (expected_powers.size() == 0 && !busy) begin
                     next_valid = 1'b1;
                     csr_modulus <= head.modulus;
                     void'(job_queue.pop_front());
                     gap_taken = 0;
                  end
               end
            end
         end
         start     <= next_start;
         csr_valid <= next_valid;
      end
   end

   // monitor
   always @(posedge clock) begin
      logic [modexp_pkg::FIELD_W-1:0] want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (expected_powers.size() == 0) begin
            $error("unexpected result: power %h with no item outstanding", rsp_power);
            mismatches++;
         end else begin
            want = expected_powers.pop_front();
            powers_checked++;
            if (rsp_valid !== 1'b1 || rsp_power !== want) begin
               $error("power: expected %h, actual %h", want, rsp_power);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int unsigned drain;
      // directed, reset modulus 3233 = 61 * 53
      queue_item('0, '0);
      queue_item('0, 1);
      queue_item('1, '0);
      queue_item('1, '1);
      queue_item(1, '1);
      queue_item(65, 17);
      queue_item(2790, 2753);
      queue_item(3233, 5);
      queue_item(3232, 2);
      queue_item(32'h8000_0000, 32'h8000_0000);
      queue_item(32'h5555_5555, 32'hAAAA_AAAA);
      queue_item(32'hAAAA_AAAA, 32'h5555_5555);
      queue_item(7, 1);
      // unit modulus
      queue_modulus(1);
      queue_item(5, '0);
      queue_item(5, 3);
      // zero modulus
      queue_modulus('0);
      queue_item(9, '0);
      queue_item(9, 7);
      queue_item('1, '1);
      // full-width modulus
      queue_modulus('1);
      queue_item(32'hFFFF_FFFE, '1);
      queue_item('1, 3);
      queue_item(32'hFFFF_FFFE, 2);
      queue_modulus(2);
      queue_item(3, '1);

      queue_random_phase('1, 33);
      queue_random_phase(32'hFFFF_FFFB, 33);
      queue_random_phase($urandom, 33);
      queue_random_phase($urandom_range(2, 65535), 33);
      queue_random_phase(32'h8000_0000, 33);
      queue_random_phase($urandom | 32'h8000_0001, 33);
      queue_random_phase(1, 6);
      queue_random_phase('0, 6);
      queue_random_phase(modexp_pkg::MODULUS_RESET, 33);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (!stim_done || expected_powers.size() != 0) @(posedge clock);
      drain = 100;
      while (drain != 0) begin
         @(posedge clock);
         drain--;
      end
      if (expected_powers.size() != 0) begin
         $error("%0d expected results never arrived", expected_powers.size());
         mismatches++;
      end

      $display("Ran %0d exponentiations over %0d modulus writes, %0d results compared.",
               items_sent, writes_done, powers_checked);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
